// ===== src/ugs_pkg.sv =====
// Shared types and constants for the per-user uplink grant statistics block.
package ugs_pkg;

  typedef enum logic [1:0] {
    CMD_PDU   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_UPDATED = 3'd0,
    STAT_IGNORED = 3'd1,
    STAT_UNKNOWN = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_SKIPPED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_WRITE
  } state_e;

  typedef struct packed {
    logic alloc;
    logic clear;
  } key_cmd_t;

  typedef struct packed {
    logic hit;
    logic free_ok;
  } key_res_t;

  localparam logic [2:0]  TYPE_PUSCH     = 3'd1;
  localparam logic [2:0]  TYPE_LAST_KNOWN = 3'd4;
  localparam logic [15:0] RNTI_NONE      = 16'h0000;
  localparam logic [15:0] RNTI_ALL       = 16'hFFFF;

  localparam int NSCAL     = 12;
  localparam int SEL_MARKS = 12;
  localparam int SEL_BINS  = 16;

  localparam int W_COUNT   = 0;
  localparam int W_PRB     = 1;
  localparam int W_MCS     = 4;
  localparam int W_TBS     = 7;
  localparam int W_LAYSUM  = 10;
  localparam int W_BYTES   = 11;

endpackage

// ===== src/ugs_key_table.sv =====
// Key table: valid bits, key words, parallel match and lowest free entry search.
module ugs_key_table #(
  parameter int MAX_USERS = 32,
  parameter int AW        = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmp_en_i,
  input  logic [31:0]       cmp_key_i,
  input  ugs_pkg::key_cmd_t cmd_i,
  input  logic [AW-1:0]     wr_idx_i,
  input  logic [31:0]       wr_key_i,
  output ugs_pkg::key_res_t res_o,
  output logic [AW-1:0]     hit_idx_o,
  output logic [AW-1:0]     free_idx_o,
  input  logic [AW-1:0]     rd_idx_i,
  output logic              rd_valid_o,
  output logic [31:0]       rd_key_o
);
  import ugs_pkg::*;

  logic [MAX_USERS-1:0] valid_q;
  logic [31:0]          key_q [MAX_USERS];
  logic [MAX_USERS-1:0] match_q;
  logic [MAX_USERS-1:0] free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear) begin
      valid_q <= '0;
    end else if (cmd_i.alloc) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      key_q[wr_idx_i] <= wr_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      for (int i = 0; i < MAX_USERS; i++) begin
        match_q[i] <= valid_q[i] && (key_q[i] == cmp_key_i);
        free_q[i]  <= !valid_q[i];
      end
    end
  end

  always_comb begin
    hit_idx_o  = '0;
    free_idx_o = '0;
    for (int i = MAX_USERS - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx_o = AW'(i);
      if (free_q[i]) free_idx_o = AW'(i);
    end
    res_o.hit     = |match_q;
    res_o.free_ok = |free_q;
  end

  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_key_o   = key_q[rd_idx_i];

endmodule

// ===== src/ugs_stat_ram.sv =====
// Statistics memory: one row per entry, registered read port, one write port.
module ugs_stat_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int NW    = 44
) (
  input  logic                 clk_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [NW-1:0][31:0]  rdata_o,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [NW-1:0][31:0]  wdata_i
);

  logic [NW-1:0][31:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/ugs_row_upd.sv =====
// Row update: counts, min/max/sum, histogram bins and highest-bin marks of one entry.
module ugs_row_upd #(
  parameter int PRB_BINS   = 8,
  parameter int MCS_BINS   = 8,
  parameter int TBS_BINS   = 8,
  parameter int LAYER_BINS = 4,
  parameter int NW         = 44
) (
  input  logic [NW-1:0][31:0] row_i,
  input  logic                alloc_i,
  input  logic [8:0]          rb_size_i,
  input  logic [4:0]          mcs_i,
  input  logic [31:0]         tb_size_i,
  input  logic                newd_i,
  input  logic [3:0]          lay_cnt_i,
  output logic [NW-1:0][31:0] row_o
);
  import ugs_pkg::*;

  localparam int OFF_PRB = SEL_BINS;
  localparam int OFF_MCS = OFF_PRB + PRB_BINS;
  localparam int OFF_TBS = OFF_MCS + MCS_BINS;
  localparam int OFF_LAY = OFF_TBS + TBS_BINS;

  function automatic logic [63:0] lay_tab_f();
    logic [63:0] t;
    t = '0;
    for (int i = 0; i < 16; i++) begin
      t[i*4 +: 4] = 4'(i % LAYER_BINS);
    end
    return t;
  endfunction

  localparam logic [63:0] LAY_TAB = lay_tab_f();

  logic [NW-1:0][31:0] base;
  logic [31:0] prb_v, mcs_v, tbs_v, lay_v;
  logic [31:0] prb_bin, mcs_bin, tbs_bin;
  logic [31:0] prb_p, mcs_p, tbs_p;

  always_comb begin
    prb_v   = 32'(rb_size_i);
    mcs_v   = 32'(mcs_i);
    tbs_v   = 32'(tb_size_i[15:0]);
    lay_v   = 32'(LAY_TAB[lay_cnt_i*4 +: 4]);
    prb_p   = prb_v * 32'(PRB_BINS);
    mcs_p   = mcs_v * 32'(MCS_BINS);
    tbs_p   = tbs_v * 32'(TBS_BINS);
    prb_bin = prb_p >> 9;
    mcs_bin = mcs_p >> 5;
    tbs_bin = tbs_p >> 16;

    for (int w = 0; w < NW; w++) begin
      if (alloc_i) begin
        base[w] = (w == W_PRB || w == W_MCS || w == W_TBS) ? '1 : '0;
      end else begin
        base[w] = row_i[w];
      end
    end

    row_o = base;
    row_o[W_COUNT] = base[W_COUNT] + 32'd1;
    if (base[W_PRB] > prb_v) row_o[W_PRB] = prb_v;
    if (base[W_PRB+1] < prb_v) row_o[W_PRB+1] = prb_v;
    row_o[W_PRB+2] = base[W_PRB+2] + prb_v;
    if (base[W_MCS] > mcs_v) row_o[W_MCS] = mcs_v;
    if (base[W_MCS+1] < mcs_v) row_o[W_MCS+1] = mcs_v;
    row_o[W_MCS+2] = base[W_MCS+2] + mcs_v;
    if (base[W_TBS] > tbs_v) row_o[W_TBS] = tbs_v;
    if (base[W_TBS+1] < tbs_v) row_o[W_TBS+1] = tbs_v;
    row_o[W_TBS+2] = base[W_TBS+2] + tbs_v;
    row_o[W_LAYSUM] = base[W_LAYSUM] + lay_v;
    if (newd_i) row_o[W_BYTES] = base[W_BYTES] + tb_size_i;

    if (base[SEL_MARKS] < prb_bin + 32'd1) row_o[SEL_MARKS] = prb_bin + 32'd1;
    if (base[SEL_MARKS+1] < mcs_bin + 32'd1) row_o[SEL_MARKS+1] = mcs_bin + 32'd1;
    if (base[SEL_MARKS+2] < tbs_bin + 32'd1) row_o[SEL_MARKS+2] = tbs_bin + 32'd1;
    if (base[SEL_MARKS+3] < lay_v + 32'd1) row_o[SEL_MARKS+3] = lay_v + 32'd1;

    for (int b = 0; b < PRB_BINS; b++) begin
      if (prb_bin == 32'(b)) row_o[OFF_PRB+b] = base[OFF_PRB+b] + 32'd1;
    end
    for (int b = 0; b < MCS_BINS; b++) begin
      if (mcs_bin == 32'(b)) row_o[OFF_MCS+b] = base[OFF_MCS+b] + 32'd1;
    end
    for (int b = 0; b < TBS_BINS; b++) begin
      if (tbs_bin == 32'(b)) row_o[OFF_TBS+b] = base[OFF_TBS+b] + 32'd1;
    end
    for (int b = 0; b < LAYER_BINS; b++) begin
      if (lay_v == 32'(b)) row_o[OFF_LAY+b] = base[OFF_LAY+b] + 32'd1;
    end
  end

endmodule

// ===== src/per_ue_uplink_grant_stats.sv =====
// Per-user uplink grant statistics: top level with control sequencer.
//
// One input channel (s_axis) carries PDU descriptors and host commands; tuser
// selects the command and the PDU type, tlast marks the last PDU of a slot
// message. One output channel (m_axis) returns exactly one result per item:
// status in tuser, entry index, new-entry flag, read word and not-empty flag
// in tdata.
// A result passes these steps: key compare against all entries at the accepting
// edge, then entry selection and row read, then row update, write-back and
// result load. One item is in flight at a time: a new item is accepted only
// after the previous one has been written back, because each item needs the
// read-modify-write of one statistics row.
// The output register holds a result until it is taken; the next item is
// accepted meanwhile and waits in its write-back cycle while the receiver
// stalls. Reset invalidates all entries and clears the not-empty and skip
// flags; statistics rows are rebuilt when an entry is allocated, so no
// clearing pass runs after reset or a clear command.
module per_ue_uplink_grant_stats #(
  parameter int MAX_USERS  = 32,
  parameter int PRB_BINS   = 8,
  parameter int MCS_BINS   = 8,
  parameter int TBS_BINS   = 8,
  parameter int LAYER_BINS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // cell_id, rnti, rb_size, mcs, tb_size, new-data flag, layer count,
  // read_index, read_select, zero fill
  input  logic [95:0] s_axis_tdata_i,
  // cmd, PDU type
  input  logic [4:0]  s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // entry_index, is_new, read_value, not-empty flag, zero fill
  output logic [39:0] m_axis_tdata_o,
  // status
  output logic [2:0]  m_axis_tuser_o
);
  import ugs_pkg::*;

  localparam int AW      = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int HT      = PRB_BINS + MCS_BINS + TBS_BINS + LAYER_BINS;
  localparam int NW      = SEL_BINS + HT;
  localparam int SEL_KEY = SEL_BINS + HT;

  state_e state_q, state_d;

  cmd_e        cmd_q;
  logic [2:0]  type_q;
  logic [31:0] key_q;
  logic [8:0]  rb_q;
  logic [4:0]  mcs_q;
  logic [31:0] tbs_q;
  logic        newd_q;
  logic [3:0]  lay_q;
  logic        last_q;
  logic [4:0]  ridx_q;
  logic [5:0]  rsel_q;

  logic skip_q, skip_d, seen_q, seen_d;

  status_e       status_q, status_d;
  logic [4:0]    eidx_q, eidx_d;
  logic          isnew_q, isnew_d;
  logic          upd_q, upd_d;
  logic [AW-1:0] entry_q, entry_d;

  logic          out_valid_q;
  status_e       out_status_q;
  logic [4:0]    out_eidx_q;
  logic          out_new_q;
  logic [31:0]   out_rval_q;
  logic          out_seen_q;

  logic        accept, out_free, fire, in_rng;
  key_cmd_t    kcmd;
  key_res_t    kres;
  logic [AW-1:0] hit_idx, free_idx, rd_addr;
  logic        rd_en, k_valid;
  logic [31:0] k_word, rval, sel_word;
  logic [NW-1:0][31:0] rdata, row_new;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign fire     = (state_q == S_WRITE) && out_free;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_rng   = 32'(ridx_q) < 32'(MAX_USERS);

  ugs_key_table #(.MAX_USERS(MAX_USERS), .AW(AW)) u_keys (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmp_en_i   (accept),
    .cmp_key_i  ({s_axis_tdata_i[15:0], s_axis_tdata_i[31:16]}),
    .cmd_i      (kcmd),
    .wr_idx_i   (entry_q),
    .wr_key_i   (key_q),
    .res_o      (kres),
    .hit_idx_o  (hit_idx),
    .free_idx_o (free_idx),
    .rd_idx_i   (AW'(ridx_q)),
    .rd_valid_o (k_valid),
    .rd_key_o   (k_word)
  );

  ugs_stat_ram #(.DEPTH(MAX_USERS), .AW(AW), .NW(NW)) u_ram (
    .clk_i   (clk_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata),
    .we_i    (fire && upd_q),
    .waddr_i (entry_q),
    .wdata_i (row_new)
  );

  ugs_row_upd #(
    .PRB_BINS(PRB_BINS), .MCS_BINS(MCS_BINS), .TBS_BINS(TBS_BINS),
    .LAYER_BINS(LAYER_BINS), .NW(NW)
  ) u_upd (
    .row_i     (rdata),
    .alloc_i   (isnew_q),
    .rb_size_i (rb_q),
    .mcs_i     (mcs_q),
    .tb_size_i (tbs_q),
    .newd_i    (newd_q),
    .lay_cnt_i (lay_q),
    .row_o     (row_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      skip_q  <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      skip_q  <= skip_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(s_axis_tuser_i[1:0]);
      type_q <= s_axis_tuser_i[4:2];
      key_q  <= {s_axis_tdata_i[15:0], s_axis_tdata_i[31:16]};
      rb_q   <= s_axis_tdata_i[40:32];
      mcs_q  <= s_axis_tdata_i[45:41];
      tbs_q  <= s_axis_tdata_i[77:46];
      newd_q <= s_axis_tdata_i[78];
      lay_q  <= s_axis_tdata_i[82:79];
      last_q <= s_axis_tlast_i;
      ridx_q <= s_axis_tdata_i[87:83];
      rsel_q <= s_axis_tdata_i[93:88];
    end
    if (state_q == S_SEARCH) begin
      status_q <= status_d;
      eidx_q   <= eidx_d;
      isnew_q  <= isnew_d;
      upd_q    <= upd_d;
      entry_q  <= entry_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    skip_d     = skip_q;
    seen_d     = seen_q;
    status_d   = STAT_IGNORED;
    eidx_d     = '0;
    isnew_d    = 1'b0;
    upd_d      = 1'b0;
    entry_d    = kres.hit ? hit_idx : free_idx;
    kcmd.alloc = fire && upd_q && isnew_q;
    kcmd.clear = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = entry_d;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        state_d = S_WRITE;
        unique case (cmd_q)
          CMD_READ: begin
            status_d = STAT_UPDATED;
            eidx_d   = ridx_q;
            rd_addr  = AW'(ridx_q);
            rd_en    = in_rng;
          end
          CMD_CLEAR: begin
            status_d   = STAT_UPDATED;
            kcmd.clear = 1'b1;
            seen_d     = 1'b0;
          end
          CMD_PDU: begin
            priority if (skip_q) begin
              status_d = STAT_SKIPPED;
              if (last_q) skip_d = 1'b0;
            end else if (type_q > TYPE_LAST_KNOWN) begin
              status_d = STAT_UNKNOWN;
              if (!last_q) skip_d = 1'b1;
            end else if (type_q == TYPE_PUSCH && key_q[15:0] != RNTI_NONE &&
                         key_q[15:0] != RNTI_ALL) begin
              seen_d = 1'b1;
              if (kres.hit || kres.free_ok) begin
                status_d = STAT_UPDATED;
                upd_d    = 1'b1;
                isnew_d  = !kres.hit;
                eidx_d   = 5'(entry_d);
                rd_en    = 1'b1;
              end else begin
                status_d = STAT_FULL;
              end
            end else begin
              status_d = STAT_IGNORED;
            end
          end
          default: begin
            status_d = STAT_IGNORED;
          end
        endcase
      end
      S_WRITE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    sel_word = '0;
    for (int w = 0; w < NW; w++) begin
      if (32'(rsel_q) == 32'(w)) sel_word = rdata[w];
    end
    rval = '0;
    if (cmd_q == CMD_READ && in_rng && k_valid) begin
      if (32'(rsel_q) < 32'(SEL_KEY)) begin
        rval = sel_word;
      end else if (32'(rsel_q) == 32'(SEL_KEY)) begin
        rval = k_word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q <= status_q;
      out_eidx_q   <= eidx_q;
      out_new_q    <= isnew_q;
      out_rval_q   <= rval;
      out_seen_q   <= seen_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {1'b0, out_seen_q, out_rval_q, out_new_q, out_eidx_q};

endmodule

// ===== src/ugs_checker.sv =====
// Port-level checks for the grant statistics block, bound to its top level.
module ugs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);
  import ugs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second transfer accepted while busy");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= STAT_SKIPPED)
    else $error("status code out of range");

  a_new_updated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[5] |-> m_axis_tuser_o == STAT_UPDATED &&
    m_axis_tdata_o[38])
    else $error("new entry without update");

endmodule

bind per_ue_uplink_grant_stats ugs_checker u_ugs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== dv/per_ue_uplink_grant_stats_tb.sv =====
// Testbench for the per-user uplink grant statistics block: random and directed items.
`timescale 1ns / 1ps

module per_ue_uplink_grant_stats_tb;
  import ugs_pkg::*;

  localparam int USERS = 32;
  localparam int NPRB = 8;
  localparam int NMCS = 8;
  localparam int NTBS = 8;
  localparam int NLAY = 4;
  localparam int NHIST = NPRB + NMCS + NTBS + NLAY;
  localparam int SEL_KEY = SEL_BINS + NHIST;
  localparam logic [2:0] TYPE_PRACH = 3'd0;
  localparam logic [2:0] TYPE_PUCCH = 3'd2;
  localparam logic [2:0] TYPE_SRS = 3'd3;
  localparam logic [2:0] TYPE_MSGA = 3'd4;
  localparam logic [2:0] TYPE_BAD_LO = 3'd5;
  localparam logic [2:0] TYPE_BAD_HI = 3'd7;
  localparam int LIMIT = 600000;

  typedef struct {
    cmd_e        cmd;
    logic [2:0]  ptype;
    logic [15:0] cell_no;
    logic [15:0] rnti;
    logic [8:0]  rb;
    logic [4:0]  mcs;
    logic [31:0] tbs;
    logic        newd;
    logic [3:0]  lay;
    logic        last;
    logic [4:0]  ridx;
    logic [5:0]  rsel;
  } pdu_t;

  typedef struct {
    status_e     status;
    logic [4:0]  idx;
    logic        is_new;
    logic [31:0] rval;
    logic        seen;
  } grant_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;
  logic [4:0]  s_axis_tuser_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  per_ue_uplink_grant_stats uut (.*);

  always #5 clk_i = ~clk_i;

  pdu_t       pending_pdus[$];
  grant_res_t expected_results[$];
  pdu_t       cur_pdu;
  int         src_idle = 0;
  int         snk_idle = 0;
  logic       hold_on = 1'b0;
  logic       stall_start = 1'b0;
  int         mismatches = 0;
  int         cycles = 0;

  logic        ent_valid[USERS];
  logic [31:0] ent_key[USERS];
  logic [31:0] ent_scal[USERS][NSCAL];
  logic [31:0] ent_hist[USERS][NHIST];
  logic [31:0] ent_mark[USERS][4];
  logic        data_seen = 1'b0;
  logic        skip_rest = 1'b0;

  logic [31:0] key_pool[40];

  function automatic void wipe_table();
    for (int e = 0; e < USERS; e++) begin
      ent_valid[e] = 1'b0;
      ent_key[e] = '0;
      for (int k = 0; k < NSCAL; k++) ent_scal[e][k] = '0;
      for (int k = 0; k < NHIST; k++) ent_hist[e][k] = '0;
      for (int k = 0; k < 4; k++) ent_mark[e][k] = '0;
    end
    data_seen = 1'b0;
  endfunction

  function automatic void track_stat(int e, int k, logic [31:0] v);
    if (ent_scal[e][k] > v) ent_scal[e][k] = v;
    if (ent_scal[e][k + 1] < v) ent_scal[e][k + 1] = v;
    ent_scal[e][k + 2] += v;
  endfunction

  function automatic void bin_hit(int e, int base, int bin, int m);
    ent_hist[e][base + bin] += 1;
    if (ent_mark[e][m] < bin + 1) ent_mark[e][m] = bin + 1;
  endfunction

  function automatic grant_res_t grant_update(pdu_t p);
    grant_res_t r;
    logic [31:0] key;
    int e, free_e;
    int t16, lb;
    r = '{STAT_IGNORED, 5'd0, 1'b0, 32'd0, 1'b0};
    if (p.cmd == CMD_READ) begin
      r.status = STAT_UPDATED;
      r.idx = p.ridx;
      if (p.rsel < SEL_MARKS) r.rval = ent_scal[p.ridx][p.rsel];
      else if (p.rsel < SEL_BINS) r.rval = ent_mark[p.ridx][p.rsel - SEL_MARKS];
      else if (p.rsel < SEL_KEY) r.rval = ent_hist[p.ridx][p.rsel - SEL_BINS];
      else if (p.rsel == SEL_KEY) r.rval = ent_valid[p.ridx] ? ent_key[p.ridx] : 32'd0;
    end else if (p.cmd == CMD_CLEAR) begin
      wipe_table();
      r.status = STAT_UPDATED;
    end else if (p.cmd == CMD_PDU) begin
      if (skip_rest) begin
        r.status = STAT_SKIPPED;
        if (p.last) skip_rest = 1'b0;
      end else if (p.ptype > TYPE_LAST_KNOWN) begin
        r.status = STAT_UNKNOWN;
        if (!p.last) skip_rest = 1'b1;
      end else if (p.ptype == TYPE_PUSCH && p.rnti != RNTI_NONE && p.rnti != RNTI_ALL) begin
        key = {p.cell_no, p.rnti};
        e = USERS;
        free_e = USERS;
        data_seen = 1'b1;
        for (int i = 0; i < USERS; i++) begin
          if (ent_valid[i] && ent_key[i] == key) begin
            e = i;
            break;
          end
          if (!ent_valid[i] && free_e == USERS) free_e = i;
        end
        if (e == USERS && free_e < USERS) begin
          e = free_e;
          r.is_new = 1'b1;
          ent_valid[e] = 1'b1;
          ent_key[e] = key;
          for (int k = 0; k < NSCAL; k++) ent_scal[e][k] = '0;
          for (int k = 0; k < NHIST; k++) ent_hist[e][k] = '0;
          for (int k = 0; k < 4; k++) ent_mark[e][k] = '0;
          ent_scal[e][W_PRB] = '1;
          ent_scal[e][W_MCS] = '1;
          ent_scal[e][W_TBS] = '1;
        end
        if (e == USERS) begin
          r.status = STAT_FULL;
        end else begin
          t16 = p.tbs[15:0];
          lb = p.lay % NLAY;
          r.status = STAT_UPDATED;
          r.idx = 5'(e);
          ent_scal[e][W_COUNT] += 1;
          track_stat(e, W_PRB, p.rb);
          bin_hit(e, 0, (p.rb * NPRB) >> 9, 0);
          track_stat(e, W_MCS, p.mcs);
          bin_hit(e, NPRB, (p.mcs * NMCS) >> 5, 1);
          track_stat(e, W_TBS, t16);
          bin_hit(e, NPRB + NMCS, (t16 * NTBS) >> 16, 2);
          bin_hit(e, NPRB + NMCS + NTBS, lb, 3);
          ent_scal[e][W_LAYSUM] += lb;
          if (p.newd) ent_scal[e][W_BYTES] += p.tbs;
        end
      end
    end
    r.seen = data_seen;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) expected_results.push_back(grant_update(cur_pdu));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_pdus.size() > 0 && $urandom_range(99) >= src_idle) begin
          cur_pdu = pending_pdus.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= {2'b0, cur_pdu.rsel, cur_pdu.ridx, cur_pdu.lay, cur_pdu.newd,
                             cur_pdu.tbs, cur_pdu.mcs, cur_pdu.rb, cur_pdu.rnti,
                             cur_pdu.cell_no};
          s_axis_tuser_i <= {cur_pdu.ptype, cur_pdu.cmd};
          s_axis_tlast_i <= cur_pdu.last;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    grant_res_t exp_r;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: tuser %0d tdata %h",
                                         m_axis_tuser_o, m_axis_tdata_o);
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tuser_o !== exp_r.status || m_axis_tdata_o[4:0] !== exp_r.idx ||
              m_axis_tdata_o[5] !== exp_r.is_new || m_axis_tdata_o[37:6] !== exp_r.rval ||
              m_axis_tdata_o[38] !== exp_r.seen) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch: exp status %0d idx %0d new %0d val %h ne %0d, ",
                     exp_r.status, exp_r.idx, exp_r.is_new, exp_r.rval, exp_r.seen);
              $display("got %0d %0d %0d %h %0d",
                       m_axis_tuser_o, m_axis_tdata_o[4:0], m_axis_tdata_o[5],
                       m_axis_tdata_o[37:6], m_axis_tdata_o[38]);
            end
          end
        end
      end
      m_axis_tready_i <= !hold_on && ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : long_stall
    wait (stall_start);
    @(negedge clk_i);
    hold_on = 1'b1;
    repeat (300) @(negedge clk_i);
    hold_on = 1'b0;
  end

  function automatic pdu_t blank();
    pdu_t p;
    p = '{CMD_PDU, TYPE_PUSCH, 16'd0, 16'd1, 9'd0, 5'd0, 32'd0, 1'b0, 4'd0, 1'b1,
          5'd0, 6'd0};
    return p;
  endfunction

  function automatic pdu_t grant(logic [31:0] key, logic [8:0] rb, logic [4:0] mcs,
                                 logic [31:0] tbs, logic [3:0] lay, logic newd);
    pdu_t p;
    p = blank();
    {p.cell_no, p.rnti} = key;
    p.rb = rb;
    p.mcs = mcs;
    p.tbs = tbs;
    p.lay = lay;
    p.newd = newd;
    return p;
  endfunction

  function automatic pdu_t stat_read(logic [4:0] idx, logic [5:0] sel);
    pdu_t p;
    p = blank();
    p.cmd = CMD_READ;
    p.ridx = idx;
    p.rsel = sel;
    return p;
  endfunction

  function automatic pdu_t random_pdu();
    pdu_t p;
    int pick;
    p = grant(key_pool[$urandom_range(39)], 9'($urandom), 5'($urandom), $urandom,
              4'($urandom), 1'($urandom));
    p.last = ($urandom_range(3) != 0);
    p.ridx = 5'($urandom);
    p.rsel = 6'($urandom);
    p.ptype = 3'($urandom);
    p.cmd = cmd_e'(2'($urandom));
    pick = $urandom_range(99);
    if (pick < 55) begin
      p.cmd = CMD_PDU;
      p.ptype = TYPE_PUSCH;
    end else if (pick < 80) begin
      p.cmd = CMD_READ;
      if ($urandom_range(3) != 0) p.rsel = 6'($urandom_range(SEL_KEY));
    end else if (pick < 81) begin
      p.cmd = CMD_CLEAR;
    end else if (pick < 85) begin
      p.cmd = CMD_PDU;
      p.rnti = $urandom_range(1) ? RNTI_NONE : RNTI_ALL;
    end else if (pick < 97) begin
      p.cmd = CMD_PDU;
    end
    return p;
  endfunction

  task automatic drain();
    wait (pending_pdus.size() == 0 && !s_axis_tvalid_i && expected_results.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    pdu_t p;
    for (int i = 0; i < 40; i++) begin
      key_pool[i] = {16'($urandom_range(3)), 16'($urandom_range(1, 30))};
    end
    key_pool[0] = {16'hFFFF, 16'hFFFE};
    key_pool[1] = {16'h0000, 16'h0001};
    key_pool[2] = {16'hA5A5, 16'h5A5A};
    wipe_table();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_pdus.push_back(grant(key_pool[1], 9'd0, 5'd0, 32'd0, 4'd0, 1'b1));
    pending_pdus.push_back(grant(key_pool[0], 9'd511, 5'd31, 32'hFFFFFFFF, 4'd15, 1'b1));
    pending_pdus.push_back(grant(key_pool[0], 9'd100, 5'd7, 32'h0001_8000, 4'd6, 1'b0));
    p = grant(key_pool[2], 9'd1, 5'd1, 32'd1, 4'd1, 1'b1);
    p.rnti = RNTI_NONE;
    pending_pdus.push_back(p);
    p.rnti = RNTI_ALL;
    pending_pdus.push_back(p);
    for (int i = 0; i < 4; i++) begin
      p = grant(key_pool[2], 9'd1, 5'd1, 32'd1, 4'd1, 1'b1);
      p.ptype = i == 0 ? TYPE_PRACH : i == 1 ? TYPE_PUCCH : i == 2 ? TYPE_SRS : TYPE_MSGA;
      pending_pdus.push_back(p);
    end
    p = blank();
    p.ptype = TYPE_BAD_LO;
    p.last = 1'b0;
    pending_pdus.push_back(p);
    p = grant(key_pool[2], 9'd5, 5'd5, 32'd5, 4'd2, 1'b1);
    p.last = 1'b0;
    pending_pdus.push_back(p);
    p.last = 1'b1;
    pending_pdus.push_back(p);
    p = blank();
    p.ptype = TYPE_BAD_HI;
    pending_pdus.push_back(p);
    p.cmd = CMD_NONE;
    pending_pdus.push_back(p);
    pending_pdus.push_back(stat_read(5'd1, 6'd0));
    pending_pdus.push_back(stat_read(5'd1, 6'd1));
    pending_pdus.push_back(stat_read(5'd1, 6'd15));
    pending_pdus.push_back(stat_read(5'd1, 6'(SEL_KEY)));
    pending_pdus.push_back(stat_read(5'd0, 6'(SEL_KEY + 1)));
    pending_pdus.push_back(stat_read(5'd31, 6'd63));
    p = blank();
    p.cmd = CMD_CLEAR;
    pending_pdus.push_back(p);
    pending_pdus.push_back(stat_read(5'd1, 6'(SEL_KEY)));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle = (ph == 1) ? 77 : (ph == 3) ? 28 : 0;
      snk_idle = (ph == 2) ? 77 : (ph == 3) ? 28 : 0;
      for (int i = 0; i < 250; i++) pending_pdus.push_back(random_pdu());
      if (ph == 0) stall_start = 1'b1;
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
